>>> design/abd_pkg.sv
// shared types, constants and register indexes of the backlight dimmer
package abd_pkg;

   // field widths
   localparam int unsigned READING_WIDTH = 12;
   localparam int unsigned LEVEL_WIDTH   = 17;
   localparam int unsigned DUTY_WIDTH    = 10;

   // q1.16 one, full brightness
   localparam logic [LEVEL_WIDTH-1:0] ONE_Q16 = 17'h10000;

   // darkness quotient has 17 bits, one restoring step per cycle
   localparam int unsigned DIV_STEPS   = 17;
   localparam int unsigned COUNT_WIDTH = $clog2(DIV_STEPS);

   // floor(x / 10) == (x * 52429) >> 19 for every x below 2^18
   localparam int unsigned RECIP_WIDTH = 16;
   localparam logic [RECIP_WIDTH-1:0] RECIP_TEN = 16'd52429;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned PROD_WIDTH  = LEVEL_WIDTH + RECIP_WIDTH;

   // signed duty product: 18-bit level times 11-bit span
   localparam int unsigned DUTY_PROD_WIDTH = LEVEL_WIDTH + 1 + DUTY_WIDTH + 1;

   // csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUTOMATIC  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRIGHT     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DARK       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_MIN   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_MAX   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THEME_HIGH = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THEME_LOW  = 3'd6;

   // register reset values
   localparam logic [READING_WIDTH-1:0] BRIGHT_RESET     = 12'd0;
   localparam logic [READING_WIDTH-1:0] DARK_RESET       = 12'd4095;
   localparam logic [DUTY_WIDTH-1:0]    DUTY_MIN_RESET   = 10'd0;
   localparam logic [DUTY_WIDTH-1:0]    DUTY_MAX_RESET   = 10'd1023;
   localparam logic [LEVEL_WIDTH-1:0]   THEME_HIGH_RESET = 17'd39322;
   localparam logic [LEVEL_WIDTH-1:0]   THEME_LOW_RESET  = 17'd26214;

   typedef struct packed {
      logic                     automatic_cfg;
      logic [READING_WIDTH-1:0] bright_reading;
      logic [READING_WIDTH-1:0] dark_reading;
      logic [DUTY_WIDTH-1:0]    duty_min;
      logic [DUTY_WIDTH-1:0]    duty_max;
      logic [LEVEL_WIDTH-1:0]   theme_high;
      logic [LEVEL_WIDTH-1:0]   theme_low;
   } abd_cfg_type;

   typedef struct packed {
      logic                     mode;
      logic [READING_WIDTH-1:0] reading;
      logic [LEVEL_WIDTH-1:0]   new_level;
   } abd_req_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0]  duty;
      logic [LEVEL_WIDTH-1:0] level;
      logic                   light_theme;
      logic                   theme_changed;
   } abd_rsp_type;

   // controller to datapath strobes
   typedef struct packed {
      logic load_in;
      logic prep;
      logic div_step;
      logic load_light;
      logic mul_avg;
      logic mul_light;
      logic update;
      logic theme;
      logic load_out;
   } abd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip_avg;
      logic empty_window;
   } abd_status_type;

endpackage

>>> design/abd_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
interface abd_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/abd_csr.sv
// configuration registers of the backlight dimmer
module abd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [abd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [abd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output abd_pkg::abd_cfg_type                cfg
);
   import abd_pkg::*;

   abd_cfg_type cfg_ff;
   abd_cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AUTOMATIC:  cfg_in.automatic_cfg  = csr_wdata[0];
            CSR_BRIGHT:     cfg_in.bright_reading = csr_wdata[READING_WIDTH-1:0];
            CSR_DARK:       cfg_in.dark_reading   = csr_wdata[READING_WIDTH-1:0];
            CSR_DUTY_MIN:   cfg_in.duty_min       = csr_wdata[DUTY_WIDTH-1:0];
            CSR_DUTY_MAX:   cfg_in.duty_max       = csr_wdata[DUTY_WIDTH-1:0];
            CSR_THEME_HIGH: cfg_in.theme_high     = csr_wdata[LEVEL_WIDTH-1:0];
            CSR_THEME_LOW:  cfg_in.theme_low      = csr_wdata[LEVEL_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.automatic_cfg  <= 1'b1;
         cfg_ff.bright_reading <= BRIGHT_RESET;
         cfg_ff.dark_reading   <= DARK_RESET;
         cfg_ff.duty_min       <= DUTY_MIN_RESET;
         cfg_ff.duty_max       <= DUTY_MAX_RESET;
         cfg_ff.theme_high     <= THEME_HIGH_RESET;
         cfg_ff.theme_low      <= THEME_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/abd_ctrl.sv
// sequencer of the backlight dimmer: steps the datapath through one item
module abd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  abd_pkg::abd_status_type status,
   output abd_pkg::abd_cmd_type    cmd
);
   import abd_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_PREP    = 4'd1;
   localparam logic [3:0] ST_DIV     = 4'd2;
   localparam logic [3:0] ST_LIGHT   = 4'd3;
   localparam logic [3:0] ST_AVG10   = 4'd4;
   localparam logic [3:0] ST_LIGHT10 = 4'd5;
   localparam logic [3:0] ST_UPDATE  = 4'd6;
   localparam logic [3:0] ST_THEME   = 4'd7;
   localparam logic [3:0] ST_DUTY    = 4'd8;

   localparam logic [COUNT_WIDTH-1:0] DIV_LAST = COUNT_WIDTH'(DIV_STEPS - 1);

   logic [3:0]             state_ff;
   logic [3:0]             state_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   // next state and datapath strobes
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.skip_avg) begin
               state_in = ST_THEME;
            end else if (status.empty_window) begin
               state_in = ST_LIGHT;
            end else begin
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (count_ff == DIV_LAST) begin
               state_in = ST_LIGHT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_LIGHT: begin
            cmd.load_light = 1'b1;
            state_in       = ST_AVG10;
         end
         ST_AVG10: begin
            cmd.mul_avg = 1'b1;
            state_in    = ST_LIGHT10;
         end
         ST_LIGHT10: begin
            cmd.mul_light = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_THEME;
         end
         ST_THEME: begin
            cmd.theme = 1'b1;
            state_in  = ST_DUTY;
         end
         ST_DUTY: begin
            // wait here while the previous result is still untaken
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/abd_dp.sv
// datapath of the backlight dimmer: divider, averaging, theme and duty
module abd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  abd_pkg::abd_cfg_type    cfg,
   input  abd_pkg::abd_req_type    req_payload,
   input  abd_pkg::abd_cmd_type    cmd,
   output abd_pkg::abd_status_type status,
   output abd_pkg::abd_rsp_type    rsp_payload
);
   import abd_pkg::*;

   // captured item
   logic                     mode_ff;
   logic [READING_WIDTH-1:0] reading_ff;
   logic [LEVEL_WIDTH-1:0]   new_level_ff;

   // divider
   logic [READING_WIDTH:0]   rem_ff;
   logic [READING_WIDTH:0]   rem_in;
   logic [READING_WIDTH-1:0] divisor_ff;
   logic [READING_WIDTH-1:0] divisor_in;
   logic [LEVEL_WIDTH-1:0]   quo_ff;
   logic [LEVEL_WIDTH-1:0]   quo_in;

   // averaging
   logic [LEVEL_WIDTH-1:0] light_ff;
   logic [LEVEL_WIDTH-1:0] light_in;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic [PROD_WIDTH-1:0]  prod_in;
   logic [LEVEL_WIDTH-1:0] avg_div_ff;
   logic [LEVEL_WIDTH-1:0] avg_div_in;
   logic [LEVEL_WIDTH-1:0] avg_ff;
   logic [LEVEL_WIDTH-1:0] avg_in;

   // theme and duty
   logic                              dark_ff;
   logic                              dark_in;
   logic                              changed_ff;
   logic                              changed_in;
   logic signed [DUTY_PROD_WIDTH-1:0] duty_prod_ff;
   logic signed [DUTY_PROD_WIDTH-1:0] duty_prod_in;
   abd_rsp_type                       rsp_ff;
   abd_rsp_type                       rsp_in;

   // combinational helpers
   logic                              empty_window;
   logic [READING_WIDTH-1:0]          clamp_hi;
   logic [READING_WIDTH-1:0]          clamped;
   logic                              rem_ge;
   logic [READING_WIDTH:0]            rem_sub;
   logic [LEVEL_WIDTH-1:0]            mul_a;
   logic [LEVEL_WIDTH-1:0]            quot_ten;
   logic [LEVEL_WIDTH:0]              avg_sum;
   logic [LEVEL_WIDTH-1:0]            new_level_sat;
   logic signed [DUTY_WIDTH:0]        duty_span;
   logic signed [DUTY_PROD_WIDTH-1:0] duty_off;
   logic [DUTY_WIDTH-1:0]             duty_val;

   assign empty_window = (cfg.dark_reading <= cfg.bright_reading);

   // clamp order: limit to dark first, then raise to bright
   always_comb begin
      clamp_hi = (reading_ff > cfg.dark_reading) ? cfg.dark_reading : reading_ff;
      clamped  = (clamp_hi < cfg.bright_reading) ? cfg.bright_reading : clamp_hi;
   end

   // one restoring division step per cycle
   always_comb begin
      rem_ge  = (rem_ff >= {1'b0, divisor_ff});
      rem_sub = rem_ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (cmd.prep) begin
         rem_in     = {1'b0, clamped - cfg.bright_reading};
         divisor_in = cfg.dark_reading - cfg.bright_reading;
         quo_in     = '0;
      end else if (cmd.div_step) begin
         rem_in = {rem_sub[READING_WIDTH-1:0], 1'b0};
         quo_in = {quo_ff[LEVEL_WIDTH-2:0], rem_ge};
      end
   end

   // ambient light, then divide-by-ten through the reciprocal multiplier
   always_comb begin
      light_in = light_ff;
      if (cmd.load_light) begin
         light_in = empty_window ? ONE_Q16 : (ONE_Q16 - quo_ff);
      end
      mul_a    = cmd.mul_light ? light_ff : avg_ff;
      prod_in  = cmd.mul_avg || cmd.mul_light ?
                 (PROD_WIDTH'(mul_a) * PROD_WIDTH'(RECIP_TEN)) : prod_ff;
      quot_ten = LEVEL_WIDTH'(prod_ff >> RECIP_SHIFT);
      avg_div_in = cmd.mul_light ? quot_ten : avg_div_ff;
   end

   // stored level: manual write or exponential average step
   always_comb begin
      new_level_sat = (new_level_ff > ONE_Q16) ? ONE_Q16 : new_level_ff;
      avg_sum = {1'b0, avg_ff} - {1'b0, avg_div_ff} + {1'b0, quot_ten};
      avg_in  = avg_ff;
      if (cmd.prep && mode_ff) begin
         avg_in = new_level_sat;
      end else if (cmd.update) begin
         avg_in = (avg_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : avg_sum[LEVEL_WIDTH-1:0];
      end
   end

   // theme hysteresis and duty product
   always_comb begin
      dark_in      = dark_ff;
      changed_in   = changed_ff;
      duty_span    = $signed({1'b0, cfg.duty_max}) - $signed({1'b0, cfg.duty_min});
      duty_prod_in = duty_prod_ff;
      if (cmd.theme) begin
         changed_in = 1'b0;
         if (dark_ff && (avg_ff > cfg.theme_high)) begin
            dark_in    = 1'b0;
            changed_in = 1'b1;
         end else if (!dark_ff && (avg_ff < cfg.theme_low)) begin
            dark_in    = 1'b1;
            changed_in = 1'b1;
         end
         duty_prod_in = DUTY_PROD_WIDTH'($signed({1'b0, avg_ff})) *
                        DUTY_PROD_WIDTH'(duty_span);
      end
   end

   // duty: divide by 2^16 truncating toward zero
   always_comb begin
      if (duty_prod_ff < 0) begin
         duty_off = (duty_prod_ff + DUTY_PROD_WIDTH'(65535)) >>> 16;
      end else begin
         duty_off = duty_prod_ff >>> 16;
      end
      duty_val = cfg.duty_min + duty_off[DUTY_WIDTH-1:0];
      rsp_in   = rsp_ff;
      if (cmd.load_out) begin
         rsp_in.duty          = duty_val;
         rsp_in.level         = avg_ff;
         rsp_in.light_theme   = ~dark_ff;
         rsp_in.theme_changed = changed_ff;
      end
   end

   // level and theme state
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff  <= ONE_Q16;
         dark_ff <= 1'b1;
      end else begin
         avg_ff  <= avg_in;
         dark_ff <= dark_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mode_ff      <= req_payload.mode;
         reading_ff   <= req_payload.reading;
         new_level_ff <= req_payload.new_level;
      end
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      quo_ff       <= quo_in;
      light_ff     <= light_in;
      prod_ff      <= prod_in;
      avg_div_ff   <= avg_div_in;
      changed_ff   <= changed_in;
      duty_prod_ff <= duty_prod_in;
      rsp_ff       <= rsp_in;
   end

   assign status.skip_avg     = mode_ff | ~cfg.automatic_cfg;
   assign status.empty_window = empty_window;
   assign rsp_payload         = rsp_ff;

endmodule

>>> design/auto_backlight_dimmer_core.sv
// Ambient-light backlight dimmer. Each request transfer is either a manual level write
// (mode 1) or one light-sensor reading (mode 0); each yields exactly one response with
// the PWM duty, the Q1.16 level and the theme flags. Requests are taken one at a time:
// a sensor tick in automatic mode runs the 17-step restoring divider that turns the
// clamped reading into the ambient light value, then the averaging steps; with an
// empty bright..dark window the divider is skipped, and a manual write or a tick in
// manual mode skips both. A finished response waits in its output register and the
// next request is accepted meanwhile; only the final step of the following item waits
// for it to be taken. Configuration registers must be written by the user through the
// csr port only while no item is in flight; the block itself does not enforce this.
module auto_backlight_dimmer_core (
   input  logic                                clock,
   input  logic                                reset,
   abd_stream_if.sink                          req_chan,
   abd_stream_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [abd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [abd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import abd_pkg::*;

   abd_cfg_type    cfg;
   abd_cmd_type    cmd;
   abd_status_type status;
   abd_req_type    req_payload;
   abd_rsp_type    rsp_payload;
   logic           req_ready;
   logic           rsp_valid;

   assign req_payload = req_chan.payload;

   // configuration registers
   abd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   abd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   abd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // stored level never exceeds full brightness
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.level <= ONE_Q16))
      else $error("level above full brightness");

   // a transfer in starts a busy period
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken again without processing");

   // the sequencer issues at most one datapath step per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath strobes");

endmodule
